// File: rtl/efm_pkg.sv
// Shared types and codes for the event queue block.
`default_nettype none

package efm_pkg;

  localparam int TYPE_W = 3;
  localparam int WORD_W = 32;

  // Command codes
  localparam logic [1:0] CMD_QUEUE = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;

  // Event type that takes part in motion merging
  localparam logic [TYPE_W-1:0] EV_MOUSE = 3'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [WORD_W-1:0] val1;
    logic [WORD_W-1:0] val2;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              got_event;
    logic [TYPE_W-1:0] out_type;
    logic [WORD_W-1:0] out_value;
    logic [WORD_W-1:0] out_value_second;
    logic [WORD_W-1:0] out_length;
    logic [WORD_W-1:0] out_tag;
    logic              overflowed;
    logic              merged;
    logic [WORD_W-1:0] dropped_tag;
  } result_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_MERGE  = 2'd1,
    OP_APPEND = 2'd2,
    OP_POP    = 2'd3
  } op_t;

endpackage

`default_nettype wire

// File: rtl/efm_in_if.sv
// Command channel: valid/ready handshake with one event command as payload.
`default_nettype none

interface efm_in_if import efm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [TYPE_W-1:0]        event_type;
  logic signed [WORD_W-1:0] value;
  logic signed [WORD_W-1:0] value_second;
  logic [WORD_W-1:0]        payload_length;
  logic [WORD_W-1:0]        payload_tag;

  modport source (
    output valid, command, event_type, value, value_second, payload_length, payload_tag,
    input  ready
  );

  modport sink (
    input  valid, command, event_type, value, value_second, payload_length, payload_tag,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/efm_out_if.sv
// Result channel: valid/ready handshake with one command result as payload.
`default_nettype none

interface efm_out_if import efm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     got_event;
  logic [TYPE_W-1:0]        out_type;
  logic signed [WORD_W-1:0] out_value;
  logic signed [WORD_W-1:0] out_value_second;
  logic [WORD_W-1:0]        out_length;
  logic [WORD_W-1:0]        out_tag;
  logic                     overflowed;
  logic                     merged;
  logic [WORD_W-1:0]        dropped_tag;

  modport source (
    output valid, got_event, out_type, out_value, out_value_second, out_length, out_tag,
           overflowed, merged, dropped_tag,
    input  ready
  );

  modport sink (
    input  valid, got_event, out_type, out_value, out_value_second, out_length, out_tag,
           overflowed, merged, dropped_tag,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/event_fifo_with_motion_merge_top.sv
// Top level: two drop-oldest event queues with mouse-motion merging.
`default_nettype none

// Two event queues (system and injected) of DEPTH entries each share one
// memory of 2*DEPTH entries. At the accept edge a transaction issues the
// memory read at the slot the command needs (newest system entry for a merge,
// oldest entry for a pop or a drop), and the S_EXEC state then modifies,
// writes back and loads the result register. A command is accepted only in
// S_IDLE, so one command is through write-back before the next is taken. A
// waiting result holds the write-back until it is taken, while the next
// command can already be accepted once write-back is done. No clearing pass
// is needed after reset: only data read from occupied slots is ever used.
module event_fifo_with_motion_merge_top import efm_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  efm_in_if.sink     in_ch,
  efm_out_if.source  out_ch
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAW = $clog2(2*DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]  LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(DEPTH);
  localparam logic [MAW-1:0] INJ_BASE  = MAW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [MAW-1:0] mem_addr(input logic inj, input logic [AW-1:0] s);
    return inj ? INJ_BASE + MAW'(s) : MAW'(s);
  endfunction

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              inj_sel_r, inj_sel_nxt;
  logic              full_r, full_nxt;
  logic [MAW-1:0]    addr_r, addr_nxt;
  entry_t            cmd_r;

  logic [AW-1:0]     sys_wr_r, sys_wr_nxt, sys_rd_r, sys_rd_nxt;
  logic [AW-1:0]     inj_wr_r, inj_wr_nxt, inj_rd_r, inj_rd_nxt;
  logic [CW-1:0]     sys_cnt_r, sys_cnt_nxt, inj_cnt_r, inj_cnt_nxt;
  logic              sys_last_mouse_r, sys_last_mouse_nxt;

  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  logic              in_fire, exec_go;
  logic [AW-1:0]     sys_newest;
  logic [AW-1:0]     q_wr, q_rd;
  logic [CW-1:0]     q_cnt;
  logic              mem_wr_en;
  logic [MAW-1:0]    mem_wr_addr;
  entry_t            mem_wr_data, mem_rd_data;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign sys_newest  = (sys_wr_r == '0) ? LAST_SLOT : sys_wr_r - AW'(1);

  // Decode the command at accept time and pick the slot to read
  always_comb begin
    op_nxt      = OP_NONE;
    inj_sel_nxt = 1'b0;
    full_nxt    = 1'b0;
    addr_nxt    = '0;
    case (in_ch.command)
      CMD_QUEUE: begin
        if (in_ch.event_type == EV_MOUSE && sys_cnt_r != '0 && sys_last_mouse_r) begin
          op_nxt   = OP_MERGE;
          addr_nxt = mem_addr(1'b0, sys_newest);
        end else begin
          op_nxt   = OP_APPEND;
          full_nxt = (sys_cnt_r == FULL_CNT);
          addr_nxt = mem_addr(1'b0, sys_rd_r);
        end
      end
      CMD_PUSH: begin
        op_nxt      = OP_APPEND;
        inj_sel_nxt = 1'b1;
        full_nxt    = (inj_cnt_r == FULL_CNT);
        addr_nxt    = mem_addr(1'b1, inj_rd_r);
      end
      CMD_POP: begin
        if (inj_cnt_r != '0) begin
          op_nxt      = OP_POP;
          inj_sel_nxt = 1'b1;
          addr_nxt    = mem_addr(1'b1, inj_rd_r);
        end else if (sys_cnt_r != '0) begin
          op_nxt   = OP_POP;
          addr_nxt = mem_addr(1'b0, sys_rd_r);
        end
      end
      default: begin
        op_nxt = OP_NONE;
      end
    endcase
  end

  assign q_wr  = inj_sel_r ? inj_wr_r  : sys_wr_r;
  assign q_rd  = inj_sel_r ? inj_rd_r  : sys_rd_r;
  assign q_cnt = inj_sel_r ? inj_cnt_r : sys_cnt_r;

  // Modify and write back, update pointers, build the result
  always_comb begin
    logic [AW-1:0] wr_n, rd_n;
    logic [CW-1:0] cnt_n;
    wr_n               = q_wr;
    rd_n               = q_rd;
    cnt_n              = q_cnt;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = addr_r;
    mem_wr_data        = cmd_r;
    out_nxt            = '0;
    sys_last_mouse_nxt = sys_last_mouse_r;
    case (op_r)
      OP_MERGE: begin
        mem_wr_en        = 1'b1;
        mem_wr_data      = mem_rd_data;
        mem_wr_data.val1 = mem_rd_data.val1 + cmd_r.val1;
        mem_wr_data.val2 = mem_rd_data.val2 + cmd_r.val2;
        out_nxt.merged   = 1'b1;
      end
      OP_APPEND: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = mem_addr(inj_sel_r, q_wr);
        wr_n        = slot_inc(q_wr);
        if (full_r) begin
          // drop oldest; its slot count stays the same
          rd_n               = slot_inc(q_rd);
          out_nxt.overflowed = 1'b1;
          out_nxt.dropped_tag = mem_rd_data.tag;
        end else begin
          cnt_n = q_cnt + CW'(1);
        end
        if (!inj_sel_r) begin
          sys_last_mouse_nxt = (cmd_r.kind == EV_MOUSE);
        end
      end
      OP_POP: begin
        rd_n                     = slot_inc(q_rd);
        cnt_n                    = q_cnt - CW'(1);
        out_nxt.got_event        = 1'b1;
        out_nxt.out_type         = mem_rd_data.kind;
        out_nxt.out_value        = mem_rd_data.val1;
        out_nxt.out_value_second = mem_rd_data.val2;
        out_nxt.out_length       = mem_rd_data.len;
        out_nxt.out_tag          = mem_rd_data.tag;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
    if (!exec_go) begin
      mem_wr_en          = 1'b0;
      wr_n               = q_wr;
      rd_n               = q_rd;
      cnt_n              = q_cnt;
      sys_last_mouse_nxt = sys_last_mouse_r;
    end
    sys_wr_nxt  = inj_sel_r ? sys_wr_r  : wr_n;
    sys_rd_nxt  = inj_sel_r ? sys_rd_r  : rd_n;
    sys_cnt_nxt = inj_sel_r ? sys_cnt_r : cnt_n;
    inj_wr_nxt  = inj_sel_r ? wr_n  : inj_wr_r;
    inj_rd_nxt  = inj_sel_r ? rd_n  : inj_rd_r;
    inj_cnt_nxt = inj_sel_r ? cnt_n : inj_cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  efm_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (addr_nxt),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      op_r             <= OP_NONE;
      inj_sel_r        <= 1'b0;
      full_r           <= 1'b0;
      sys_wr_r         <= '0;
      sys_rd_r         <= '0;
      sys_cnt_r        <= '0;
      inj_wr_r         <= '0;
      inj_rd_r         <= '0;
      inj_cnt_r        <= '0;
      sys_last_mouse_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      sys_wr_r         <= sys_wr_nxt;
      sys_rd_r         <= sys_rd_nxt;
      sys_cnt_r        <= sys_cnt_nxt;
      inj_wr_r         <= inj_wr_nxt;
      inj_rd_r         <= inj_rd_nxt;
      inj_cnt_r        <= inj_cnt_nxt;
      sys_last_mouse_r <= sys_last_mouse_nxt;
      out_valid_r      <= out_valid_nxt;
      if (in_fire) begin
        op_r      <= op_nxt;
        inj_sel_r <= inj_sel_nxt;
        full_r    <= full_nxt;
      end
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r     <= addr_nxt;
      cmd_r.kind <= in_ch.event_type;
      cmd_r.val1 <= in_ch.value;
      cmd_r.val2 <= in_ch.value_second;
      cmd_r.len  <= in_ch.payload_length;
      cmd_r.tag  <= in_ch.payload_tag;
    end
    if (exec_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.got_event        = out_r.got_event;
  assign out_ch.out_type         = out_r.out_type;
  assign out_ch.out_value        = out_r.out_value;
  assign out_ch.out_value_second = out_r.out_value_second;
  assign out_ch.out_length       = out_r.out_length;
  assign out_ch.out_tag          = out_r.out_tag;
  assign out_ch.overflowed       = out_r.overflowed;
  assign out_ch.merged           = out_r.merged;
  assign out_ch.dropped_tag      = out_r.dropped_tag;

  a_sys_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sys_cnt_r <= FULL_CNT) else $error("system queue count above depth");

  a_inj_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inj_cnt_r <= FULL_CNT) else $error("injected queue count above depth");

  a_sys_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (sys_wr_r == sys_rd_r) |-> (sys_cnt_r == '0 || sys_cnt_r == FULL_CNT))
    else $error("system queue pointers disagree with count");

  a_merge_mouse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_MERGE) |-> (mem_rd_data.kind == EV_MOUSE))
    else $error("merge into a newest entry that is not a mouse event");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> ($stable(sys_cnt_r) && $stable(inj_cnt_r)))
    else $error("queue count moved outside write-back");

endmodule

`default_nettype wire

// File: rtl/efm_store.sv
// Entry memory for both queues: one write port, one registered read port.
`default_nettype none

module efm_store import efm_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(2*DEPTH)-1:0]  rd_addr,
  output entry_t                           rd_data,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(2*DEPTH)-1:0]  wr_addr,
  input  wire entry_t                      wr_data
);

  entry_t mem [2*DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
